### rtl/core/hbc_pkg.sv
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared types and constants of the hue bar color generator: field widths,
// ramp constants and the request/response bundle of the divider.
// ----------------------------------------------------------------------------
package hbc_pkg;

    // field widths
    localparam int POS_W  = 16;
    localparam int SIZE_W = 15;
    localparam int CHAN_W = 8;
    localparam int SEG_W  = 13;

    // divider widths
    localparam int DIV_W     = 18;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    // register reset value
    localparam logic [SIZE_W-1:0] BAR_SIZE_RESET = 15'd768;

    // dividends used while deriving the per-size constants
    localparam logic [DIV_W-1:0] DVD_INV_SIZE = 18'd131072;  // 2^17
    localparam logic [DIV_W-1:0] DVD_CEIL     = 18'd32767;
    localparam logic [DIV_W-1:0] DVD_INV_SEG  = 18'd32768;   // 2^15
    localparam logic [DIV_W-1:0] RAMP_SCALE   = 18'd255000;
    localparam logic [SIZE_W-1:0] SEGMENTS    = 15'd6;

    // divide by six as multiply by ceil(2^20/6), exact for any 15-bit size
    localparam logic [17:0] SEG_RECIP = 18'd174763;

    // divide by 1000 as multiply by floor(2^20/1000) plus one correction
    localparam logic [10:0] RECIP_1000 = 11'd1048;
    localparam logic [9:0]  RAMP_DIV   = 10'd1000;
    localparam logic [CHAN_W-1:0] FULL = 8'd255;

    // segment index along the bar
    localparam logic [3:0] SEG_GREEN_UP  = 4'd0;
    localparam logic [3:0] SEG_RED_DOWN  = 4'd1;
    localparam logic [3:0] SEG_BLUE_UP   = 4'd2;
    localparam logic [3:0] SEG_GREEN_DN  = 4'd3;
    localparam logic [3:0] SEG_RED_UP    = 4'd4;
    localparam logic [3:0] SEG_BLUE_DOWN = 4'd5;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [SIZE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

### rtl/core/hbc_div.sv
// ----------------------------------------------------------------------------
// hbc_div
// Restoring divider, one quotient bit per cycle, used to derive the
// per-size constants after reset and after each register write.
// ----------------------------------------------------------------------------
module hbc_div
    import hbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SIZE_W-1:0]    r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [SIZE_W-1:0]    r_dsr;

    logic [SIZE_W:0]      w_shift;
    logic [SIZE_W:0]      w_diff;
    logic                 w_ge;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dsr});
        w_diff  = w_shift - {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_STEPS;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[SIZE_W-1:0] : w_shift[SIZE_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // done is a single pulse after the last step
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_run)
        else $error("divider done while still running");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run && !i_req.start && r_cnt == DIV_CNT_W'(1)) |=> (r_done && !r_run))
        else $error("divider did not finish after last step");

    // step count stays in range while running
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_cnt != '0) && (r_cnt <= DIV_STEPS))
        else $error("divider step count out of range");

endmodule

### rtl/core/hue_bar_color_generator.sv
// ----------------------------------------------------------------------------
// hue_bar_color_generator
// Maps a signed position along a hue bar to an 8-bit red, green, blue triple.
// ----------------------------------------------------------------------------
// Usage
//   Input: pulse start with i_position while busy is low; one beat is taken
//   per cycle, so a full-rate stream of positions passes with no gaps.
//   Output: o_valid is high for one cycle with o_red, o_green, o_blue, once
//   the beat has passed the pipeline. The receiver cannot stall the block;
//   every stage moves each cycle and valid bits travel with the data.
//   Config: i_cfg_data is the bar size, written when i_cfg_valid and
//   o_cfg_ready are both high. The write, and reset, start a derive pass:
//   the segment length comes from a multiply by the reciprocal of six, and
//   the ramp slope, the modulo offset and two reciprocals from four
//   divisions on a shared one-bit-per-cycle divider. busy is high and
//   o_cfg_ready low during that pass.
//   Reset loads a bar size of 768 and then runs the derive pass.
//   The modulo and the segment split use multiply by reciprocal with one
//   correction step; the pipeline depth of eleven is set by that chain.
//   Bar sizes below six give red 255, green 0, blue 0 for every position.
// ----------------------------------------------------------------------------
module hue_bar_color_generator
    import hbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [POS_W-1:0]  i_position,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data
);

    // derive sequencer states
    localparam logic [2:0] CS_IDLE = 3'd0;
    localparam logic [2:0] CS_INV1 = 3'd2;
    localparam logic [2:0] CS_CEIL = 3'd3;
    localparam logic [2:0] CS_INV2 = 3'd4;
    localparam logic [2:0] CS_K    = 3'd5;

    logic [2:0]        r_state;
    logic              r_issued;
    logic [SIZE_W-1:0] r_bar_size;

    // derived constants
    logic [SEG_W-1:0]  r_seg;
    logic [SIZE_W-1:0] r_inv1;
    logic [15:0]       r_mofs;
    logic [15:0]       r_inv2;
    logic [DIV_W-1:0]  r_k;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic     w_cfg_wr;
    logic     w_accept;
    logic [28:0] w_mofs;
    logic [32:0] w_seg_prod;

    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = (r_state == CS_IDLE);
    assign busy        = (r_state != CS_IDLE);
    assign w_accept    = start && !busy;

    // segment length as size times the reciprocal of six
    assign w_seg_prod = 33'(r_bar_size) * 33'(SEG_RECIP);

    always_ff @(posedge i_clk) begin
        r_seg <= w_seg_prod[32:20];
    end

    // divider request per sequencer step
    always_comb begin
        w_req.start = (r_state != CS_IDLE) && !r_issued;
        unique case (r_state)
            CS_INV1: begin
                w_req.dividend = DVD_INV_SIZE;
                w_req.divisor  = r_bar_size;
            end
            CS_CEIL: begin
                w_req.dividend = DVD_CEIL;
                w_req.divisor  = r_bar_size;
            end
            CS_INV2: begin
                w_req.dividend = DVD_INV_SEG;
                w_req.divisor  = {2'b0, r_seg};
            end
            CS_K: begin
                w_req.dividend = RAMP_SCALE;
                w_req.divisor  = {2'b0, r_seg};
            end
            default: begin
                w_req.dividend = '0;
                w_req.divisor  = '0;
            end
        endcase
    end

    hbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // smallest multiple of the size that reaches 32768
    assign w_mofs = 29'(w_rsp.quotient[13:0] + 14'd1) * 29'(r_bar_size);

    // sequencer and size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CS_INV1;
            r_issued   <= 1'b0;
            r_bar_size <= BAR_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_bar_size <= i_cfg_data;
            r_state    <= CS_INV1;
            r_issued   <= 1'b0;
        end else if (r_state != CS_IDLE) begin
            if (!r_issued) begin
                r_issued <= 1'b1;
            end else if (w_rsp.done) begin
                r_issued <= 1'b0;
                unique case (r_state)
                    CS_INV1: r_state <= CS_CEIL;
                    CS_CEIL: r_state <= CS_INV2;
                    CS_INV2: r_state <= CS_K;
                    default: r_state <= CS_IDLE;
                endcase
            end
        end
    end

    // capture of derived constants
    always_ff @(posedge i_clk) begin
        if (r_issued && w_rsp.done) begin
            unique case (r_state)
                CS_INV1: r_inv1 <= w_rsp.quotient[SIZE_W-1:0];
                CS_CEIL: r_mofs <= w_mofs[15:0];
                CS_INV2: r_inv2 <= w_rsp.quotient[15:0];
                CS_K:    r_k    <= w_rsp.quotient;
                default: r_k    <= r_k;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // color pipeline
    // ------------------------------------------------------------------
    logic [11:1] r_v;

    logic [16:0] r_a1, r_a2, r_a3;
    logic [31:0] r_p2;
    logic [16:0] r_qs3;
    logic [14:0] r_w4, r_w5;
    logic [30:0] r_p5;
    logic [3:0]  r_q6, r_q7, r_q8, r_q9, r_q10;
    logic [14:0] r_rem6;
    logic [SEG_W-1:0] r_r7;
    logic [17:0] r_kp8, r_kp9;
    logic [28:0] r_m9;
    logic [CHAN_W-1:0] r_ramp10;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    logic [31:0] w_p2;
    logic [29:0] w_qs3;
    logic [16:0] w_rem4;
    logic [16:0] w_w4;
    logic [30:0] w_p5;
    logic [3:0]  w_q6;
    logic [16:0] w_qseg6;
    logic [30:0] w_kp8;
    logic [28:0] w_m9;
    logic [7:0]  w_q10;
    logic [17:0] w_qm10;
    logic [17:0] w_rem10;
    logic [CHAN_W-1:0] w_up;
    logic [CHAN_W-1:0] w_down;
    logic [CHAN_W-1:0] n_red, n_green, n_blue;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[10:1], w_accept};
        end
    end

    // wrap by floored modulo: offset by a multiple of size, then reduce
    always_comb begin
        w_p2   = 32'(r_a1) * 32'(r_inv1);
        w_qs3  = 30'(r_p2[31:17]) * 30'(r_bar_size);
        w_rem4 = r_a3 - r_qs3;
        w_w4   = (w_rem4 >= {2'b0, r_bar_size}) ? w_rem4 - {2'b0, r_bar_size} : w_rem4;
    end

    // split into segment index and offset
    always_comb begin
        w_p5    = 31'(r_w4) * 31'(r_inv2);
        w_q6    = r_p5[18:15];
        w_qseg6 = 17'(w_q6) * 17'(r_seg);
    end

    // ramp value k*r/1000
    always_comb begin
        w_kp8   = 31'(r_k) * 31'(r_r7);
        w_m9    = 29'(r_kp8) * 29'(RECIP_1000);
        w_q10   = r_m9[27:20];
        w_qm10  = 18'(w_q10) * 18'(RAMP_DIV);
        w_rem10 = r_kp9 - w_qm10;
    end

    always_ff @(posedge i_clk) begin
        r_a1  <= 17'({i_position[POS_W-1], i_position}) + {1'b0, r_mofs};
        r_a2  <= r_a1;
        r_p2  <= w_p2;
        r_a3  <= r_a2;
        r_qs3 <= w_qs3[16:0];
        r_w4  <= w_w4[14:0];
        r_w5  <= r_w4;
        r_p5  <= w_p5;
        r_q6  <= w_q6;
        r_rem6 <= r_w5 - w_qseg6[14:0];
        if (r_rem6 >= {2'b0, r_seg}) begin
            r_r7 <= SEG_W'(r_rem6 - {2'b0, r_seg});
            r_q7 <= r_q6 + 4'd1;
        end else begin
            r_r7 <= r_rem6[SEG_W-1:0];
            r_q7 <= r_q6;
        end
        r_kp8 <= w_kp8[17:0];
        r_q8  <= r_q7;
        r_m9  <= w_m9;
        r_kp9 <= r_kp8;
        r_q9  <= r_q8;
        r_ramp10 <= w_q10 + {7'b0, (w_rem10 >= {8'b0, RAMP_DIV})};
        r_q10 <= r_q9;
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    // channel select per segment; beyond the sixth segment is the tail
    always_comb begin
        w_up   = r_ramp10;
        w_down = FULL - r_ramp10;
        n_red   = FULL;
        n_green = '0;
        n_blue  = '0;
        if (r_bar_size >= SEGMENTS) begin
            unique case (r_q10)
                SEG_GREEN_UP: begin
                    n_red = FULL;   n_green = w_up;   n_blue = '0;
                end
                SEG_RED_DOWN: begin
                    n_red = w_down; n_green = FULL;   n_blue = '0;
                end
                SEG_BLUE_UP: begin
                    n_red = '0;     n_green = FULL;   n_blue = w_up;
                end
                SEG_GREEN_DN: begin
                    n_red = '0;     n_green = w_down; n_blue = FULL;
                end
                SEG_RED_UP: begin
                    n_red = w_up;   n_green = '0;     n_blue = FULL;
                end
                SEG_BLUE_DOWN: begin
                    n_red = FULL;   n_green = '0;     n_blue = w_down;
                end
                default: begin
                    n_red = FULL;   n_green = '0;     n_blue = '0;
                end
            endcase
        end
    end

    assign o_valid = r_v[11];
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // every accepted beat leaves the pipeline with o_valid high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##11 o_valid)
        else $error("result missing eleven cycles after accept");

    // a size write always starts a derive pass
    a_cfg_derive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> busy)
        else $error("size write did not start derive pass");

    // the divider only answers while the sequencer waits on it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state != CS_IDLE) && r_issued)
        else $error("divider result with no pending step");

endmodule
